@@ src/sbpd_pkg.sv @@
// Shared types, constants and the log weight table for the spectrum band
// level block. No dependencies; sbpd_ctrl, sbpd_datapath and the top import it.
package sbpd_pkg;

	// Fixed field widths.
	localparam int BIN_W   = 24;
	localparam int DECAY_W = 16;
	localparam int LEVEL_W = 17;
	localparam int IDX_W   = 5;
	localparam int CFG_W   = 6;
	localparam int ROM_W   = 15;
	localparam int GAIN_W  = 17;
	localparam int FRAC_W  = 12;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_BINS_PER_BAND = 2'd0;
	localparam cfg_idx_t CFG_BAND_COUNT    = 2'd1;
	localparam logic [CFG_W-1:0] BINS_PER_BAND_RST = 6'd8;
	localparam logic [CFG_W-1:0] BAND_COUNT_RST    = 6'd30;

	// Gain window thresholds in Q.16 and output clamp values.
	localparam int TH_LO1    = 328;
	localparam int TH_HI1    = 590;
	localparam int TH_LO2    = 655;
	localparam int TH_HI2    = 6554;
	localparam int TH_HI3    = 32768;
	localparam int LEVEL_ONE = 65536;
	localparam logic [LEVEL_W-1:0] LEVEL_CAP = 17'd58982;

	// Gains in Q.12.
	localparam logic [GAIN_W-1:0] GAIN_9PI = 17'd115811;
	localparam logic [GAIN_W-1:0] GAIN_3PI = 17'd38604;
	localparam logic [GAIN_W-1:0] GAIN_PI  = 17'd12868;

	// ln(n+2) in Q3.12 for n = 0..63.
	localparam logic [ROM_W-1:0] LOG_ROM [64] = '{
		15'd2839,  15'd4500,  15'd5678,  15'd6592,  15'd7339,  15'd7970,  15'd8517,  15'd9000,
		15'd9431,  15'd9822,  15'd10178, 15'd10506, 15'd10810, 15'd11092, 15'd11357, 15'd11605,
		15'd11839, 15'd12060, 15'd12271, 15'd12470, 15'd12661, 15'd12843, 15'd13017, 15'd13185,
		15'd13345, 15'd13500, 15'd13649, 15'd13792, 15'd13931, 15'd14066, 15'd14196, 15'd14322,
		15'd14444, 15'd14563, 15'd14678, 15'd14790, 15'd14900, 15'd15006, 15'd15110, 15'd15211,
		15'd15309, 15'd15406, 15'd15500, 15'd15592, 15'd15682, 15'd15770, 15'd15856, 15'd15941,
		15'd16024, 15'd16105, 15'd16184, 15'd16262, 15'd16339, 15'd16414, 15'd16488, 15'd16560,
		15'd16632, 15'd16702, 15'd16770, 15'd16838, 15'd16905, 15'd16970, 15'd17035, 15'd17098
	};

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_GAIN,
		ST_HOLD
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic capture;
		logic mul;
		logic gain;
		logic hold;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic band_done;
	} status_t;

endpackage

@@ src/sbpd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sbpd_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/sbpd_ctrl.sv @@
// Controller state machine for the spectrum band level block: input handshake,
// band math sequencing and the output valid flag. Depends on sbpd_pkg.
module sbpd_ctrl import sbpd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.band_done) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL:  state_nxt = ST_GAIN;
			ST_GAIN: state_nxt = ST_HOLD;
			ST_HOLD: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.accept  = in_valid;
				cmd.capture = in_valid && status.band_done;
			end
			ST_MUL:  cmd.mul  = 1'b1;
			ST_GAIN: cmd.gain = 1'b1;
			ST_HOLD: cmd.hold = slot_free;
			default: in_ready = 1'b0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid flag: set when a band result is loaded, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.hold) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	// A result is never loaded over one that has not been taken.
	a_hold_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hold |-> (!out_valid_q || out_ready))
		else $error("band result loaded over a pending result");

	// Output valid only rises right after the hold step.
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_HOLD))
		else $error("output valid raised outside the hold step");

	// A completed band starts the multiply step in the next cycle.
	a_capture_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_MUL))
		else $error("band capture not followed by multiply");

	// Multiply is always followed by the gain step.
	a_mul_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_GAIN))
		else $error("multiply step not followed by gain step");
`endif

endmodule

@@ src/sbpd_datapath.sv @@
// Datapath for the spectrum band level block: bin accumulation, log weight
// multiply, piecewise gain, clamp and held-level falloff. Depends on
// sbpd_pkg and sbpd_ram.
module sbpd_datapath import sbpd_pkg::*; #(
	parameter int MAX_BANDS         = 32,
	parameter int MAX_BINS_PER_BAND = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [CFG_W-1:0]   bins_per_band,
	input  logic [CFG_W-1:0]   band_count,
	input  logic [BIN_W-1:0]   bin_value,
	input  logic               first_bin,
	input  logic [DECAY_W-1:0] decay_amount,
	output logic [LEVEL_W-1:0] band_value,
	output logic [IDX_W-1:0]   band_index,
	output logic               last_band
);

	localparam int CNT_W  = $clog2(MAX_BINS_PER_BAND + 1);
	localparam int BAND_W = $clog2(MAX_BANDS + 1);
	localparam int SUM_W  = BIN_W + CNT_W;
	localparam int PROD_W = SUM_W + ROM_W;
	localparam int V_W    = PROD_W - FRAC_W;
	localparam int ADDR_W = MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1;
	localparam int LIM_W  = CFG_W + 1;
	localparam int GP_W   = 15 + GAIN_W;

	// Accumulation state.
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [BAND_W-1:0] band_q;

	// Band math pipeline.
	logic [SUM_W-1:0]   sum_s1;
	logic [BAND_W-1:0]  band_s1;
	logic [DECAY_W-1:0] decay_s1;
	logic               last_s1;
	logic [V_W-1:0]     v_s2;
	logic [LEVEL_W-1:0] lvl_s3;

	// Output register.
	logic [LEVEL_W-1:0] band_value_q;
	logic [IDX_W-1:0]   band_index_q;
	logic               last_band_q;

	// Held-level store flags.
	logic [MAX_BANDS-1:0] held_vld_q;
	logic                 rd_vld_q;
	logic [LEVEL_W-1:0]   rd_data;

	logic [LIM_W-1:0]  eff_bins;
	logic [LIM_W-1:0]  eff_bands;
	logic [SUM_W-1:0]  sum_base;
	logic [CNT_W-1:0]  cnt_base;
	logic [BAND_W-1:0] band_base;
	logic [CNT_W-1:0]  cnt_inc;
	logic [SUM_W-1:0]  sum_inc;
	logic              ignore_bin;
	logic              done;
	logic [PROD_W-1:0] prod;
	logic [GAIN_W-1:0] gain_sel;
	logic              gain_en;
	logic [GP_W-1:0]   gprod;
	logic [V_W-1:0]    gained;
	logic [LEVEL_W-1:0] lvl;
	logic [LEVEL_W-1:0] held;
	logic signed [LEVEL_W:0] diff;
	logic signed [LEVEL_W:0] lvl_ext;
	logic [LEVEL_W-1:0] new_held;
	logic [ADDR_W-1:0]  addr;

	// Effective register values, clamped to the supported range.
	always_comb begin
		if (bins_per_band == '0) begin
			eff_bins = LIM_W'(1);
		end else if ({1'b0, bins_per_band} > LIM_W'(MAX_BINS_PER_BAND)) begin
			eff_bins = LIM_W'(MAX_BINS_PER_BAND);
		end else begin
			eff_bins = {1'b0, bins_per_band};
		end
		if (band_count == '0) begin
			eff_bands = LIM_W'(1);
		end else if ({1'b0, band_count} > LIM_W'(MAX_BANDS)) begin
			eff_bands = LIM_W'(MAX_BANDS);
		end else begin
			eff_bands = {1'b0, band_count};
		end
	end

	// Per-bin accumulation; a first bin restarts the frame.
	always_comb begin
		sum_base   = first_bin ? '0 : sum_q;
		cnt_base   = first_bin ? '0 : cnt_q;
		band_base  = first_bin ? '0 : band_q;
		ignore_bin = LIM_W'(band_base) >= eff_bands;
		cnt_inc    = cnt_base + CNT_W'(1);
		sum_inc    = sum_base + SUM_W'(bin_value);
		done       = !ignore_bin && (LIM_W'(cnt_inc) >= eff_bins);
	end

	assign status.band_done = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			cnt_q  <= '0;
			band_q <= '0;
		end else if (cmd.accept) begin
			if (ignore_bin) begin
				sum_q  <= sum_base;
				cnt_q  <= cnt_base;
				band_q <= band_base;
			end else if (done) begin
				sum_q  <= '0;
				cnt_q  <= '0;
				band_q <= band_base + BAND_W'(1);
			end else begin
				sum_q  <= sum_inc;
				cnt_q  <= cnt_inc;
				band_q <= band_base;
			end
		end
	end

	// Capture the finished band sum.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sum_s1   <= sum_inc;
			band_s1  <= band_base;
			decay_s1 <= decay_amount;
			last_s1  <= (LIM_W'(band_base) + LIM_W'(1)) == eff_bands;
		end
	end

	// Log weight multiply, truncated to Q.16.
	assign prod = PROD_W'(sum_s1) * PROD_W'(LOG_ROM[6'(band_s1)]);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			v_s2 <= prod[PROD_W-1:FRAC_W];
		end
	end

	// Piecewise gain on open intervals, then clamp above one.
	always_comb begin
		gain_en  = 1'b1;
		gain_sel = GAIN_PI;
		if (v_s2 > V_W'(TH_LO1) && v_s2 < V_W'(TH_HI1)) begin
			gain_sel = GAIN_9PI;
		end else if (v_s2 > V_W'(TH_LO2) && v_s2 < V_W'(TH_HI2)) begin
			gain_sel = GAIN_3PI;
		end else if (v_s2 > V_W'(TH_HI2) && v_s2 < V_W'(TH_HI3)) begin
			gain_sel = GAIN_PI;
		end else begin
			gain_en = 1'b0;
		end
		gprod  = GP_W'(v_s2[14:0]) * GP_W'(gain_sel);
		gained = gain_en ? V_W'(gprod[GP_W-1:FRAC_W]) : v_s2;
		lvl    = (gained > V_W'(LEVEL_ONE)) ? LEVEL_CAP : gained[LEVEL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.gain) begin
			lvl_s3 <= lvl;
		end
	end

	// Held level: rise at once, otherwise fall by the decay, floored at zero.
	assign addr = ADDR_W'(band_s1);

	sbpd_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (MAX_BANDS)
	) u_held_ram (
		.clk     (clk),
		.wr_en   (cmd.hold),
		.wr_addr (addr),
		.wr_data (new_held),
		.rd_en   (cmd.mul),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (cmd.hold) begin
				held_vld_q[addr] <= 1'b1;
			end
			if (cmd.mul) begin
				rd_vld_q <= held_vld_q[addr];
			end
		end
	end

	always_comb begin
		held     = rd_vld_q ? rd_data : '0;
		diff     = $signed({1'b0, held}) - $signed({2'b00, decay_s1});
		lvl_ext  = $signed({1'b0, lvl_s3});
		new_held = (lvl_ext >= diff) ? lvl_s3 : diff[LEVEL_W-1:0];
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			band_value_q <= new_held;
			band_index_q <= IDX_W'(band_s1);
			last_band_q  <= last_s1;
		end
	end

	assign band_value = band_value_q;
	assign band_index = band_index_q;
	assign last_band  = last_band_q;

endmodule

@@ src/spectrum_band_peak_decay_top.sv @@
// A bin that does not finish a band is taken while the block is idle; a bin that
// finishes a band occupies the block through the capture, multiply, gain and
// hold update steps, and no new bin is taken until they are done. Its result is
// registered at the hold update, which waits while the previous result is untaken.
// The held-level RAM has one read and one write port; per-band valid flags make
// it read as zero after reset, with no clearing pass. Reset is asynchronous.
// Top level: configuration registers, controller and datapath. Depends on
// sbpd_pkg, sbpd_ctrl, sbpd_datapath and sbpd_ram.
module spectrum_band_peak_decay_top import sbpd_pkg::*; #(
	parameter int MAX_BANDS         = 32,
	parameter int MAX_BINS_PER_BAND = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BIN_W-1:0]   bin_value,
	input  logic               first_bin,
	input  logic [DECAY_W-1:0] decay_amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [LEVEL_W-1:0] band_value,
	output logic [IDX_W-1:0]   band_index,
	output logic               last_band
);

	logic [CFG_W-1:0] bins_per_band_q;
	logic [CFG_W-1:0] band_count_q;
	cmd_t             cmd;
	status_t          status;

	// Configuration registers; unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_per_band_q <= BINS_PER_BAND_RST;
			band_count_q    <= BAND_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BINS_PER_BAND: bins_per_band_q <= cfg_data;
				CFG_BAND_COUNT:    band_count_q    <= cfg_data;
				default:           bins_per_band_q <= bins_per_band_q;
			endcase
		end
	end

	sbpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sbpd_datapath #(
		.MAX_BANDS         (MAX_BANDS),
		.MAX_BINS_PER_BAND (MAX_BINS_PER_BAND)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.bins_per_band (bins_per_band_q),
		.band_count    (band_count_q),
		.bin_value     (bin_value),
		.first_bin     (first_bin),
		.decay_amount  (decay_amount),
		.band_value    (band_value),
		.band_index    (band_index),
		.last_band     (last_band)
	);

endmodule
